FILE: rtl/cyclic_cellular_automaton_step_defines.svh
// assertion macros shared by the cyclic cellular automaton rtl
`ifndef CYCLIC_CELLULAR_AUTOMATON_STEP_DEFINES_SVH
`define CYCLIC_CELLULAR_AUTOMATON_STEP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked on clk outside reset
`define CCAS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccas assertion failed");
// next-cycle implication, checked on clk outside reset
`define CCAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccas assertion failed");
`else
`define CCAS_ASSERT_SAME(lbl, ante, cons)
`define CCAS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ccas_pkg.sv
// constants, types and helpers of the cyclic cellular automaton
package ccas_pkg;

	localparam int NUM_CELLS = 513;
	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = (NUM_CELLS + WORD_W - 1) / WORD_W;
	localparam int LAST_BIT  = (NUM_CELLS - 1) % WORD_W;
	localparam int CNT_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IDX_W     = 6;
	localparam int OP_W      = 2;
	localparam int RULE_W    = 8;
	localparam int HOLD_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_TRIG = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RULE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

	localparam logic [RULE_W-1:0] RULE_RESET = 8'd108;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd172;

	typedef logic [WORD_W-1:0] word_t;

	// per-cycle commands from the sequencer to one word cell
	typedef struct packed {
		logic gen;
		logic shift;
		logic load;
	} cell_ctl_t;

	// cells of word w that lie inside the ring
	function automatic word_t word_mask(input int w);
		int used;
		used = NUM_CELLS - w * WORD_W;
		if (used >= WORD_W) begin
			return '1;
		end
		return (word_t'(1) << used) - word_t'(1);
	endfunction

endpackage

FILE: rtl/ccas_if.sv
// valid/ready channels for load/tick beats in and generation words out
interface ccas_in_if;
	logic                             valid;
	logic                             ready;
	logic [ccas_pkg::OP_W-1:0]        operation;
	logic [ccas_pkg::IDX_W-1:0]       word_index;
	logic [ccas_pkg::WORD_W-1:0]      load_word;

	modport source (output valid, operation, word_index, load_word, input ready);
	modport sink (input valid, operation, word_index, load_word, output ready);
endinterface

interface ccas_out_if;
	logic                             valid;
	logic                             ready;
	logic [ccas_pkg::IDX_W-1:0]       out_index;
	logic [ccas_pkg::WORD_W-1:0]      cell_word;
	logic                             last_word;

	modport source (output valid, out_index, cell_word, last_word, input ready);
	modport sink (input valid, out_index, cell_word, last_word, output ready);
endinterface

FILE: rtl/cyclic_cellular_automaton_step.sv
// top level of the cyclic cellular automaton: sequencer and row of word cells
//
// a ring of ccas_pkg::NUM_CELLS binary cells held in a row of 64-bit word cells;
// load beats (operation load) write one word, out-of-range indexes are dropped;
// trigger beats arm a pending trigger in external mode; frame-tick beats either
// count down the hold timer (timed mode) or consume the pending trigger, and when
// a generation fires every cell computes its next word in the same cycle from the
// 8-bit rule with wraparound neighbors. the row then rotates one word per cycle
// while the output register is free or being drained, through the chain of cells,
// and word 0 of the chain feeds an output register, so a generation leaves as
// NUM_WORDS beats (9 at 513 cells), lowest word first, last_word on the final one;
// the first word is offered once the cells hold the new generation and word 0 has
// been registered. a firing tick closes the input until the last word of its
// generation has entered the output register, so an output stall keeps it closed
// longer; load, trigger and non-firing tick beats do not close it.
// configuration writes are expected only while the block is idle.
`include "cyclic_cellular_automaton_step_defines.svh"

module cyclic_cellular_automaton_step (
	input  logic                               clk,
	input  logic                               arst_n,
	ccas_in_if.sink                            in_ch,
	ccas_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [ccas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ccas_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic [ccas_pkg::RULE_W-1:0] rule_q;
	logic [ccas_pkg::HOLD_W-1:0] hold_q;
	logic                        ext_q;

	// generation timing state
	logic [ccas_pkg::HOLD_W-1:0] frames_q;
	logic                        trig_q;

	// emission sequencer
	logic                        busy_q;
	logic [ccas_pkg::CNT_W-1:0]  count_q;

	// output register
	logic                        ovalid_q;
	logic [ccas_pkg::IDX_W-1:0]  oindex_q;
	ccas_pkg::word_t             oword_q;
	logic                        olast_q;

	logic accept;
	logic tick;
	logic fire;
	logic emit;
	logic emit_last;

	ccas_pkg::word_t words [ccas_pkg::NUM_WORDS];

	// input handshake: closed while a generation is being emitted
	assign in_ch.ready = !busy_q;
	assign accept      = in_ch.valid && in_ch.ready;
	assign tick        = accept && (in_ch.operation == ccas_pkg::OP_TICK);

	// a tick fires on a pending trigger (external) or an expiring countdown (timed)
	assign fire = tick && (ext_q ? trig_q : (frames_q <= ccas_pkg::HOLD_W'(1)));

	// one rotation step whenever the output register is free or being drained
	assign emit      = busy_q && (!ovalid_q || out_ch.ready);
	assign emit_last = (count_q == ccas_pkg::CNT_W'(ccas_pkg::NUM_WORDS - 1));

	// configuration writes, index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= ccas_pkg::RULE_RESET;
			hold_q <= ccas_pkg::HOLD_RESET;
			ext_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ccas_pkg::REG_RULE: rule_q <= cfg_data[ccas_pkg::RULE_W-1:0];
				ccas_pkg::REG_HOLD: hold_q <= cfg_data[ccas_pkg::HOLD_W-1:0];
				ccas_pkg::REG_MODE: ext_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hold countdown: a write to the hold register reloads it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= ccas_pkg::HOLD_RESET;
		end else if (cfg_we && (cfg_index == ccas_pkg::REG_HOLD)) begin
			frames_q <= cfg_data[ccas_pkg::HOLD_W-1:0];
		end else if (tick && !ext_q) begin
			if (fire) begin
				frames_q <= hold_q;
			end else begin
				frames_q <= frames_q - ccas_pkg::HOLD_W'(1);
			end
		end
	end

	// pending trigger: armed only in external mode, survives a mode change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= 1'b0;
		end else if (accept && (in_ch.operation == ccas_pkg::OP_TRIG) && ext_q) begin
			trig_q <= 1'b1;
		end else if (tick && ext_q) begin
			trig_q <= 1'b0;
		end
	end

	// emission sequencer: word count of the rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (fire) begin
			busy_q  <= 1'b1;
			count_q <= '0;
		end else if (emit) begin
			if (emit_last) begin
				busy_q  <= 1'b0;
				count_q <= '0;
			end else begin
				count_q <= count_q + ccas_pkg::CNT_W'(1);
			end
		end
	end

	// output register, loaded from the head of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oindex_q <= ccas_pkg::IDX_W'(count_q);
			oword_q  <= words[0];
			olast_q  <= emit_last;
		end
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.out_index = oindex_q;
	assign out_ch.cell_word = oword_q;
	assign out_ch.last_word = olast_q;

	// chain of word cells: each rotates into its lower neighbor, word 0 wraps to the end
	for (genvar w = 0; w < ccas_pkg::NUM_WORDS; w++) begin : g_cell
		localparam int PREV = (w + ccas_pkg::NUM_WORDS - 1) % ccas_pkg::NUM_WORDS;
		localparam int NEXT = (w + 1) % ccas_pkg::NUM_WORDS;
		// top cell of the previous word; for word 0 that is the last cell of the ring
		localparam int LBIT = (w == 0) ? ccas_pkg::LAST_BIT : ccas_pkg::WORD_W - 1;

		ccas_pkg::cell_ctl_t ctl;

		assign ctl.gen   = fire;
		assign ctl.shift = emit;
		assign ctl.load  = accept && (in_ch.operation == ccas_pkg::OP_LOAD) &&
			(in_ch.word_index == ccas_pkg::IDX_W'(w));

		ccas_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.rule      (rule_q),
			.mask      (ccas_pkg::word_mask(w)),
			.left_bit  (words[PREV][LBIT]),
			.right_bit (words[NEXT][0]),
			.shift_in  (words[NEXT]),
			.load_word (in_ch.load_word),
			.word      (words[w])
		);
	end

	// a firing tick starts a fresh rotation at word zero
	`CCAS_ASSERT_NEXT(a_fire_starts, fire, busy_q && (count_q == '0))
	// the final rotation step ends the emission and reopens the input
	`CCAS_ASSERT_NEXT(a_last_ends, emit && emit_last, !busy_q && in_ch.ready)
	// a beat marked last always carries the index of the final word
	`CCAS_ASSERT_SAME(a_last_index, ovalid_q && olast_q,
		oindex_q == ccas_pkg::IDX_W'(ccas_pkg::NUM_WORDS - 1))

endmodule

FILE: rtl/ccas_cell.sv
// one 64-cell word of the ring: load, next generation, rotate to neighbor
module ccas_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ccas_pkg::cell_ctl_t           ctl,
	input  logic [ccas_pkg::RULE_W-1:0]   rule,
	input  ccas_pkg::word_t               mask,
	input  logic                          left_bit,
	input  logic                          right_bit,
	input  ccas_pkg::word_t               shift_in,
	input  ccas_pkg::word_t               load_word,
	output ccas_pkg::word_t               word
);

	ccas_pkg::word_t word_q;
	ccas_pkg::word_t next_word;

	always_comb begin
		logic       l;
		logic       r;
		logic [2:0] k;
		for (int j = 0; j < ccas_pkg::WORD_W; j++) begin
			if (j == 0) begin
				l = left_bit;
			end else begin
				l = word_q[j-1];
			end
			if (j == ccas_pkg::WORD_W - 1) begin
				r = right_bit;
			end else if (mask[j+1]) begin
				r = word_q[j+1];
			end else begin
				r = right_bit;
			end
			k = {word_q[j], l, r};
			next_word[j] = mask[j] & rule[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.load) begin
			word_q <= load_word & mask;
		end else if (ctl.gen) begin
			word_q <= next_word;
		end else if (ctl.shift) begin
			word_q <= shift_in;
		end
	end

	assign word = word_q;

endmodule

FILE: bench/tb_top.sv
// self-checking testbench for the cyclic cellular automaton step block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// operation code with no meaning, the block drops it
	localparam logic [ccas_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	localparam ccas_pkg::word_t ONES = {ccas_pkg::WORD_W{1'b1}};
	localparam int    IDLE_LIMIT   = 2000; // cycles with no beat on either side
	localparam int    LONG_STALL   = 150;  // output hold-off that backs up the input
	localparam int    RAND_PHASES  = 10;
	localparam int    PHASE_BEATS  = 35;
	localparam int    QUIET_PHASE  = 8;    // from this phase on nobody idles
	localparam int    STALL_PHASE  = 3;
	localparam int    PAUSE_PHASE  = 5;
	localparam int    MAX_REPORTS  = 10;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	// one line of the directed table: a beat or a register write,
	// with the generation typed in where it is obvious
	typedef struct packed {
		row_kind_t                      kind;
		logic [ccas_pkg::OP_W-1:0]      op;
		logic [ccas_pkg::IDX_W-1:0]     idx;
		logic [ccas_pkg::CFG_IDX_W-1:0] regno;
		ccas_pkg::word_t                data;
		logic                           known;
		ccas_pkg::word_t                known_word;
	} stim_row_t;

	// one word of a generation as it should leave the block
	typedef struct {
		logic [ccas_pkg::IDX_W-1:0] out_idx;
		ccas_pkg::word_t            cells;
		logic                       last;
	} gen_word_t;

	localparam int DIR_ROWS = 38;
	localparam stim_row_t PLAN [DIR_ROWS] = '{
		// reset rule on an empty ring gives an empty ring
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_HOLD, 64'd1, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b1, 64'd0},
		// loads: full words, cells past the ring end, indexes past the row
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd0,  ccas_pkg::REG_RULE, ONES,  1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd8,  ccas_pkg::REG_RULE, ONES,  1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd9,  ccas_pkg::REG_RULE, ONES,  1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd63, ccas_pkg::REG_RULE,
			64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		// all-ones and all-zero rules ignore the neighborhood
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'hFF, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b1, ONES},
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'h00, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b1, 64'd0},
		// wraparound: cells at both ends of the ring and in the middle
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'h5A, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd0,  ccas_pkg::REG_RULE,
			64'h8000_0000_0000_0001, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd4,  ccas_pkg::REG_RULE,
			64'hA5A5_5A5A_F0F0_0F0F, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_LOAD, 6'd8,  ccas_pkg::REG_RULE, 64'd1, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		// unused operation, then a trigger that timed mode drops
		'{ROW_BEAT, OP_SPARE,          6'd63, ccas_pkg::REG_RULE, ONES,  1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TRIG, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		// external mode: a tick with no trigger, then a double trigger for one generation
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_MODE, 64'd1, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TRIG, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TRIG, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		// pending trigger lives through a trip to timed mode and back
		'{ROW_BEAT, ccas_pkg::OP_TRIG, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_MODE, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_MODE, 64'd1, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		// hold of zero acts like one
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_MODE, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_HOLD, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		// countdown of three, then the longest hold
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_HOLD, 64'd3, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG,  ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_HOLD, 64'hFFFF, 1'b0, 64'd0},
		'{ROW_BEAT, ccas_pkg::OP_TICK, 6'd0,  ccas_pkg::REG_RULE, 64'd0, 1'b0, 64'd0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ccas_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ccas_pkg::CFG_DATA_W-1:0] cfg_data;

	ccas_in_if  in_ch ();
	ccas_out_if out_ch ();

	cyclic_cellular_automaton_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted state of the ring and its registers
	ccas_pkg::word_t             ring_cells [ccas_pkg::NUM_WORDS];
	logic [ccas_pkg::RULE_W-1:0] rule_cur;
	logic [ccas_pkg::HOLD_W-1:0] hold_cur;
	logic [ccas_pkg::HOLD_W-1:0] hold_count;
	bit              ext_cur;
	bit              trig_armed;

	gen_word_t       words_due [$];   // generation words still to come out
	int              fault_count;
	int              idle_cycles;
	bit              quiet;           // no idling on either side
	bit              stall_long;      // ask the receiver for one long hold-off

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// cells of word w that lie on the ring
	function automatic ccas_pkg::word_t ring_mask(input int w);
		ccas_pkg::word_t m;
		for (int b = 0; b < ccas_pkg::WORD_W; b++) begin
			m[b] = ((w * ccas_pkg::WORD_W + b) < ccas_pkg::NUM_CELLS);
		end
		return m;
	endfunction

	// one generation: every cell looks up center, left, right in the rule
	function automatic void evolve_ring();
		ccas_pkg::word_t prev [ccas_pkg::NUM_WORDS];
		ccas_pkg::word_t nxt [ccas_pkg::NUM_WORDS];
		int              lft;
		int              rgt;
		logic [2:0]      nb;
		prev = ring_cells;
		for (int w = 0; w < ccas_pkg::NUM_WORDS; w++) begin
			nxt[w] = '0;
		end
		for (int i = 0; i < ccas_pkg::NUM_CELLS; i++) begin
			lft = (i == 0) ? ccas_pkg::NUM_CELLS - 1 : i - 1;
			rgt = (i == ccas_pkg::NUM_CELLS - 1) ? 0 : i + 1;
			nb = {prev[i / ccas_pkg::WORD_W][i % ccas_pkg::WORD_W],
				prev[lft / ccas_pkg::WORD_W][lft % ccas_pkg::WORD_W],
				prev[rgt / ccas_pkg::WORD_W][rgt % ccas_pkg::WORD_W]};
			nxt[i / ccas_pkg::WORD_W][i % ccas_pkg::WORD_W] = rule_cur[nb];
		end
		ring_cells = nxt;
	endfunction

	// apply one accepted beat; queue the generation words if one fires
	function automatic bit predict_beat(input logic [ccas_pkg::OP_W-1:0] op,
			input logic [ccas_pkg::IDX_W-1:0] idx, input ccas_pkg::word_t data);
		bit fire;
		fire = 1'b0;
		case (op)
			ccas_pkg::OP_LOAD: begin
				if (idx < ccas_pkg::NUM_WORDS) begin
					ring_cells[idx] = data & ring_mask(idx);
				end
			end
			ccas_pkg::OP_TRIG: begin
				if (ext_cur) begin
					trig_armed = 1'b1;
				end
			end
			ccas_pkg::OP_TICK: begin
				if (ext_cur) begin
					if (trig_armed) begin
						trig_armed = 1'b0;
						fire = 1'b1;
					end
				end else if (hold_count <= 1) begin
					hold_count = hold_cur;
					fire = 1'b1;
				end else begin
					hold_count = hold_count - 1'b1;
				end
			end
			default: ;
		endcase
		if (fire) begin
			evolve_ring();
			for (int w = 0; w < ccas_pkg::NUM_WORDS; w++) begin
				words_due.push_back('{ccas_pkg::IDX_W'(w), ring_cells[w],
					w == ccas_pkg::NUM_WORDS - 1});
			end
		end
		return fire;
	endfunction

	function automatic void note_fault(input string what, input ccas_pkg::word_t want,
			input ccas_pkg::word_t got);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
		end
	endfunction

	// one beat into the block, with an occasional idle burst ahead of it
	task automatic send_beat(input logic [ccas_pkg::OP_W-1:0] op,
			input logic [ccas_pkg::IDX_W-1:0] idx, input ccas_pkg::word_t data,
			input bit known, input ccas_pkg::word_t known_word);
		int        gap;
		int        base;
		bit        fired;
		gen_word_t tmp;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= op;
		in_ch.word_index <= idx;
		in_ch.load_word  <= data;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		fired = predict_beat(op, idx, data);
		// typed-in generation replaces the predicted one
		if (fired && known) begin
			base = words_due.size() - ccas_pkg::NUM_WORDS;
			for (int w = 0; w < ccas_pkg::NUM_WORDS; w++) begin
				tmp = words_due[base + w];
				tmp.cells = known_word & ring_mask(w);
				words_due[base + w] = tmp;
			end
		end
	endtask

	// stop offering, wait for every generation word, then let the block settle
	task automatic drain(input int settle);
		in_ch.valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// one register write; the task drops the enable again before it returns
	task automatic write_reg(input logic [ccas_pkg::CFG_IDX_W-1:0] which,
			input logic [ccas_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (which)
			ccas_pkg::REG_RULE: rule_cur = val[ccas_pkg::RULE_W-1:0];
			ccas_pkg::REG_HOLD: begin
				hold_cur   = val;
				hold_count = val;
			end
			ccas_pkg::REG_MODE: ext_cur = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// receiver: bursts of hold-off and of ready, one long hold-off on request
	initial begin
		int n;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_long) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stall_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				n = $urandom_range(1, 12);
				repeat (n) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				n = $urandom_range(1, 16);
				repeat (n) @(posedge clk);
			end
		end
	end

	// every word that leaves is checked against the oldest one due
	always @(posedge clk) begin : check_out
		gen_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (words_due.size() == 0) begin
				note_fault("unexpected word", '0, out_ch.cell_word);
			end else begin
				want = words_due.pop_front();
				if (out_ch.out_index !== want.out_idx) begin
					note_fault("out_index", ccas_pkg::word_t'(want.out_idx),
						ccas_pkg::word_t'(out_ch.out_index));
				end
				if (out_ch.cell_word !== want.cells) begin
					note_fault("cell_word", want.cells, out_ch.cell_word);
				end
				if (out_ch.last_word !== want.last) begin
					note_fault("last_word", ccas_pkg::word_t'(want.last),
						ccas_pkg::word_t'(out_ch.last_word));
				end
			end
		end
	end

	// watchdog: too long without a beat on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("tb_top: errors");
					$finish;
				end
			end
		end
	end

	// main sequence: reset, directed table, random phases, wind-down
	initial begin
		int                         r;
		int                         pick;
		logic [ccas_pkg::OP_W-1:0]  op;
		logic [ccas_pkg::IDX_W-1:0] idx;
		ccas_pkg::word_t            data;
		logic [15:0]                hold_pick;
		logic [7:0]                 rule_pick;

		// predictor starts from the reset state
		for (int w = 0; w < ccas_pkg::NUM_WORDS; w++) begin
			ring_cells[w] = '0;
		end
		rule_cur    = ccas_pkg::RULE_RESET;
		hold_cur    = ccas_pkg::HOLD_RESET;
		hold_count  = ccas_pkg::HOLD_RESET;
		ext_cur     = 1'b0;
		trig_armed  = 1'b0;
		fault_count = 0;
		idle_cycles = 0;
		quiet       = 1'b0;
		stall_long  = 1'b0;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= ccas_pkg::REG_RULE;
		cfg_data         <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.operation  <= ccas_pkg::OP_TICK;
		in_ch.word_index <= '0;
		in_ch.load_word  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (r = 0; r < DIR_ROWS; r++) begin
			if (PLAN[r].kind == ROW_CFG) begin
				drain(4);
				write_reg(PLAN[r].regno, PLAN[r].data[ccas_pkg::CFG_DATA_W-1:0]);
			end else begin
				send_beat(PLAN[r].op, PLAN[r].idx, PLAN[r].data, PLAN[r].known,
					PLAN[r].known_word);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain(4);
			quiet = (ph >= QUIET_PHASE);
			pick = $urandom_range(0, 5);
			rule_pick = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
			pick = $urandom_range(0, 9);
			hold_pick = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(5, 40)) :
				16'($urandom_range(1, 4));
			write_reg(ccas_pkg::REG_RULE, ccas_pkg::CFG_DATA_W'(rule_pick));
			write_reg(ccas_pkg::REG_HOLD, hold_pick);
			write_reg(ccas_pkg::REG_MODE, ccas_pkg::CFG_DATA_W'($urandom_range(0, 1)));
			// receiver holds off while beats keep coming, so the block backs up
			if (ph == STALL_PHASE) begin
				stall_long = 1'b1;
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// sender waits for the block to empty completely
				if (ph == PAUSE_PHASE && n == PHASE_BEATS / 2) begin
					drain(4);
				end
				pick = $urandom_range(0, 99);
				if (ext_cur) begin
					op = (pick < 35) ? ccas_pkg::OP_TRIG : (pick < 72) ? ccas_pkg::OP_TICK :
						(pick < 97) ? ccas_pkg::OP_LOAD : OP_SPARE;
				end else begin
					op = (pick < 50) ? ccas_pkg::OP_TICK : (pick < 88) ? ccas_pkg::OP_LOAD :
						(pick < 96) ? ccas_pkg::OP_TRIG : OP_SPARE;
				end
				// mostly indexes on the row, now and then any index
				if (op == ccas_pkg::OP_LOAD && $urandom_range(0, 9) != 0) begin
					idx = ccas_pkg::IDX_W'($urandom_range(0, ccas_pkg::NUM_WORDS - 1));
				end else begin
					idx = ccas_pkg::IDX_W'($urandom_range(0, 63));
				end
				// sparse words make the rule's patterns easier to spot
				if ($urandom_range(0, 3) == 0) begin
					data = ccas_pkg::word_t'(1) << $urandom_range(0, ccas_pkg::WORD_W - 1);
				end else begin
					data = {$urandom(), $urandom()};
				end
				send_beat(op, idx, data, 1'b0, '0);
			end
		end

		drain(20);
		if (fault_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
